FILE: sv/lru_id_tracker_unit_macros.svh
// assertion macros for the lru id tracker
// expects aclk and aresetn in the scope of use
`ifndef LRU_ID_TRACKER_UNIT_MACROS_SVH
`define LRU_ID_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, skipped while in reset
`define LIT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while in reset
`define LIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lit_pkg.sv
// shared types and constants for the lru id tracker
// no dependencies
package lit_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_W         = 64;
    localparam int CFG_W        = 7;
    localparam int FILL_W       = 7;
    localparam int OUT_W        = 80;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_ENTRIES = 1'b0;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // broadcast control to every cell, already gated by execute
    typedef struct packed {
        logic pop_shift;   // every cell takes its upper neighbor
        logic hit_shift;   // cells at or above the hit take their upper neighbor
        logic load_en;     // the addressed cell takes the new identifier
    } lit_cell_ctrl_t;

endpackage

FILE: sv/lit_prefix.sv
// inclusive prefix-or network over the cell hit flags
// depends on nothing but its parameter
module lit_prefix #(
    parameter int N = 64
) (
    input  logic [N-1:0] hit_i,
    output logic [N-1:0] pre_o
);

    localparam int LEVELS = $clog2(N);

    logic [N-1:0] lvl [LEVELS+1];

    assign lvl[0] = hit_i;

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
            end else begin : g_pass
                assign lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign pre_o = lvl[LEVELS];

endmodule

FILE: sv/lit_cell.sv
// one storage cell of the recency chain: holds one identifier,
// compares it with the item and shifts toward the least recent end; uses lit_pkg
module lit_cell import lit_pkg::*; #(
    parameter int CNT_W = 7,
    parameter int K     = 0
) (
    input  logic                 aclk,
    input  lit_cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]     count,
    input  logic [CNT_W-1:0]     load_idx,
    input  logic [ID_W-1:0]      ident,
    input  logic [ID_W-1:0]      up_data,
    input  logic                 pre_i,
    output logic [ID_W-1:0]      data_o,
    output logic                 hit_o
);

    logic [ID_W-1:0] data_reg;
    logic [ID_W-1:0] data_next;

    assign hit_o  = (count > CNT_W'(K)) && (data_reg == ident);
    assign data_o = data_reg;

    always_comb begin
        data_next = data_reg;
        if (ctrl.load_en && (load_idx == CNT_W'(K))) begin
            data_next = ident;
        end else if (ctrl.pop_shift || (ctrl.hit_shift && pre_i)) begin
            data_next = up_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

FILE: sv/lru_id_tracker_unit.sv
// Recency list of 64-bit identifiers, built as a chain of cells; one item per
// clock cycle sustained while m_tready stays high, each item passing through the
// input register and then the result register. The clock period is set by the
// parallel compare in every cell followed by the prefix-or network that tells each
// cell whether to shift. No clearing pass after reset; cells above the fill count
// are never read. Depends on lit_pkg, lit_cell, lit_prefix and the macro header.
`include "lru_id_tracker_unit_macros.svh"

module lru_id_tracker_unit import lit_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [63:0] ident
    input  logic              s_tuser,   // [0] func
    // result items
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] status, [64:1] popped_ident, [65] pop_valid, [72:66] fill_count,
    // [73] is_empty, [74] overflow, [79:75] zero
    output logic [OUT_W-1:0]  m_tdata,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // configuration
    logic [CFG_W-1:0] max_entries_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_ENTRIES);
    assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? 32'(max_entries_reg) : 32'd0;

    // input skid register
    logic            in_valid_reg;
    logic            in_func_reg;
    logic [ID_W-1:0] in_ident_reg;
    logic            exec;

    // result register
    logic            m_tvalid_reg;
    logic            out_status_reg;
    logic [ID_W-1:0] out_popped_reg;
    logic            out_pvalid_reg;
    logic [FILL_W-1:0] out_fill_reg;
    logic            out_empty_reg;
    logic            out_ovf_reg;

    // list state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;

    assign exec     = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || exec;

    // cell chain
    logic [ID_W-1:0]     cell_data [CAPACITY];
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] pre_vec;
    lit_cell_ctrl_t      cell_ctrl;
    logic [CNT_W-1:0]    load_idx;

    logic is_access;
    logic is_pop;
    logic hit_any;
    logic insert_ok;
    logic list_empty;

    assign is_access  = (in_func_reg == FUNC_ACCESS);
    assign is_pop     = (in_func_reg == FUNC_POP);
    assign hit_any    = |hit_vec;
    assign list_empty = (count_reg == '0);
    // saturation to the chain length is covered by the second term
    assign insert_ok  = (CMP_W'(count_reg) < CMP_W'(max_entries_reg))
                        && (count_reg != CNT_W'(CAPACITY));

    lit_prefix #(.N(CAPACITY)) u_prefix (
        .hit_i (hit_vec),
        .pre_o (pre_vec)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ID_W-1:0] up;
        if (k == CAPACITY - 1) begin : g_top
            assign up = '0;
        end else begin : g_mid
            assign up = cell_data[k+1];
        end
        lit_cell #(.CNT_W(CNT_W), .K(k)) u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .count    (count_reg),
            .load_idx (load_idx),
            .ident    (in_ident_reg),
            .up_data  (up),
            .pre_i    (pre_vec[k]),
            .data_o   (cell_data[k]),
            .hit_o    (hit_vec[k])
        );
    end

    always_comb begin
        cell_ctrl.pop_shift = exec && is_pop && !list_empty;
        cell_ctrl.hit_shift = exec && is_access && hit_any;
        cell_ctrl.load_en   = exec && is_access && (hit_any || insert_ok);
        // a hit rejoins at the top of the held run, a new one lands just above it
        load_idx = hit_any ? (count_reg - CNT_W'(1)) : count_reg;

        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (is_access) begin
            if (!hit_any) begin
                if (insert_ok) begin
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end else if (!list_empty) begin
            count_next = count_reg - CNT_W'(1);
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RST;
            in_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
        end else begin
            if (cfg_wr) begin
                max_entries_reg <= pwdata[CFG_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (exec) begin
                in_valid_reg <= 1'b0;
            end
            if (exec) begin
                m_tvalid_reg <= 1'b1;
                count_reg    <= count_next;
                ovf_reg      <= ovf_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg  <= s_tuser;
            in_ident_reg <= s_tdata;
        end
        if (exec) begin
            out_status_reg <= (is_pop && list_empty) ? STATUS_EMPTY : STATUS_OK;
            out_pvalid_reg <= is_pop && !list_empty;
            out_popped_reg <= (is_pop && !list_empty) ? cell_data[0] : '0;
            out_fill_reg   <= FILL_W'(count_next);
            out_empty_reg  <= (count_next == '0);
            out_ovf_reg    <= ovf_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_ovf_reg, out_empty_reg, out_fill_reg,
                       out_pvalid_reg, out_popped_reg, out_status_reg};

    `LIT_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "fill count above chain length")
    `LIT_ASSERT_IMPL(a_single_hit, 1'b1, $onehot0(hit_vec),
        "identifier held in more than one cell")
    `LIT_ASSERT_NEXT(a_hit_keeps_count, exec && is_access && hit_any,
        count_reg == $past(count_reg), "hit changed the fill count")
    `LIT_ASSERT_NEXT(a_empty_pop, exec && is_pop && list_empty,
        m_tvalid && (m_tdata[0] == STATUS_EMPTY) && !m_tdata[65],
        "pop on empty list not reported")
    `LIT_ASSERT_NEXT(a_pop_clears_ovf, exec && is_pop && !list_empty,
        !ovf_reg, "successful pop left overflow set")

endmodule
